// File: rtl/core/ubxfp_pkg.sv
// Shared constants and result type for the binary GNSS frame parser.
package ubxfp_pkg;

  // Frame sync bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Frame status codes
  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_GOOD = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // Default payload buffer depth
  localparam int DEFAULT_BUF_DEPTH = 256;

  // One result item
  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] declared_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        payload_stored;
    logic [8:0]  stored_count;
  } res_t;

endpackage

// File: rtl/core/ubx_frame_parser.sv
// Binary GNSS frame parser, Fletcher-8 check, single byte per cycle if unstalled.
//
// Usage: feed received serial bytes on rx_byte with in_valid; a byte is taken at a
// rising edge where in_valid is high and in_stall is low. Every byte gives exactly
// one result item on the output channel (out_valid / out_stall): frame status,
// class, id, declared length, payload byte with its buffer index and stored flag,
// and the saturating stored count.
// A taken byte's result is registered, in the skid register if a result waits.
// Throughput: one byte per cycle unless stalled; the per-byte parse step and
// the 8-bit checksum adds sit between the input port and the result register.
// Stall: a two-entry output stage (result register plus skid register) lets one
// more byte in while a result waits; in_stall rises only when both are full,
// and a stalled result holds its value.
// Reset (rst, synchronous): the parser waits for the first sync byte, all frame
// registers and counts clear, and both output entries empty.
module ubx_frame_parser
  import ubxfp_pkg::*;
#(
  parameter int BUF_DEPTH = DEFAULT_BUF_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id,
  output logic [15:0] declared_length,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic        payload_stored,
  output logic [8:0]  stored_count
);

  localparam int KW = $clog2(BUF_DEPTH + 1);
  localparam logic [KW-1:0] DEPTH_K = KW'(BUF_DEPTH);

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
    PH_PAYLOAD, PH_CK_A, PH_CK_B
  } phase_t;

  // Parser state
  phase_t        phase, phase_next;
  logic [7:0]    class_reg, class_reg_next;
  logic [7:0]    id_reg, id_reg_next;
  logic [7:0]    sum_a, sum_a_next;
  logic [7:0]    sum_b, sum_b_next;
  logic [15:0]   length_reg, length_reg_next;
  logic [15:0]   bytes_left, bytes_left_next;
  logic [KW-1:0] kept_count, kept_count_next;

  // Output stage
  res_t res_next, res_out, res_skid;
  logic skid_valid;

  logic accept;
  logic take;
  logic [7:0] fold_a;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  assign fold_a   = sum_a + rx_byte;

  // Parse one byte
  always_comb begin
    phase_next      = phase;
    class_reg_next  = class_reg;
    id_reg_next     = id_reg;
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    length_reg_next = length_reg;
    bytes_left_next = bytes_left;
    kept_count_next = kept_count;
    res_next        = '0;

    unique case (phase)
      PH_SYNC1: begin
        if (rx_byte == SYNC_FIRST) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) phase_next = PH_CLASS;
        else if (rx_byte != SYNC_FIRST) phase_next = PH_SYNC1;
      end
      PH_CLASS: begin
        class_reg_next = rx_byte;
        sum_a_next     = rx_byte;
        sum_b_next     = rx_byte;
        phase_next     = PH_ID;
      end
      PH_ID: begin
        id_reg_next = rx_byte;
        sum_a_next  = fold_a;
        sum_b_next  = sum_b + fold_a;
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_reg_next = {8'h00, rx_byte};
        sum_a_next      = fold_a;
        sum_b_next      = sum_b + fold_a;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_reg_next = {rx_byte, length_reg[7:0]};
        bytes_left_next = {rx_byte, length_reg[7:0]};
        kept_count_next = '0;
        sum_a_next      = fold_a;
        sum_b_next      = sum_b + fold_a;
        // Zero length skips the payload
        phase_next = ({rx_byte, length_reg[7:0]} == 16'h0000) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_a_next             = fold_a;
        sum_b_next             = sum_b + fold_a;
        res_next.payload_valid = 1'b1;
        res_next.payload_byte  = rx_byte;
        // Keep the byte while the buffer has room
        if (kept_count < DEPTH_K) begin
          res_next.payload_stored = 1'b1;
          res_next.payload_index  = 8'(kept_count);
          kept_count_next         = kept_count + KW'(1);
        end
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left == 16'd1) phase_next = PH_CK_A;
      end
      PH_CK_A: begin
        if (rx_byte != sum_a) begin
          res_next.frame_status = STATUS_BAD;
          phase_next            = PH_SYNC1;
        end else begin
          phase_next = PH_CK_B;
        end
      end
      PH_CK_B: begin
        res_next.frame_status = (rx_byte == sum_b) ? STATUS_GOOD : STATUS_BAD;
        phase_next            = PH_SYNC1;
      end
      default: begin
        phase_next = PH_SYNC1;
      end
    endcase

    res_next.msg_class       = class_reg_next;
    res_next.msg_id          = id_reg_next;
    res_next.declared_length = length_reg_next;
    res_next.stored_count    = 9'(kept_count_next);
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC1;
      class_reg  <= '0;
      id_reg     <= '0;
      sum_a      <= '0;
      sum_b      <= '0;
      length_reg <= '0;
      bytes_left <= '0;
      kept_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      class_reg  <= class_reg_next;
      id_reg     <= id_reg_next;
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      length_reg <= length_reg_next;
      bytes_left <= bytes_left_next;
      kept_count <= kept_count_next;
    end
  end

  // Result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // Refill the result register from the skid entry
        if (take) begin
          res_out    <= res_skid;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid || take) begin
          res_out   <= res_next;
          out_valid <= 1'b1;
        end else begin
          res_skid   <= res_next;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign frame_status    = res_out.frame_status;
  assign msg_class       = res_out.msg_class;
  assign msg_id          = res_out.msg_id;
  assign declared_length = res_out.declared_length;
  assign payload_valid   = res_out.payload_valid;
  assign payload_byte    = res_out.payload_byte;
  assign payload_index   = res_out.payload_index;
  assign payload_stored  = res_out.payload_stored;
  assign stored_count    = res_out.stored_count;

  // Skid entry is only used behind a full result register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry full while result register empty");

  // A stored byte is always a payload byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_stored |-> payload_valid)
    else $error("stored flag without payload byte");

  // A frame end never coincides with a payload byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status != STATUS_NONE) |-> !payload_valid)
    else $error("frame end reported on a payload byte");

  // A stalled-back result is held while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_out))
    else $error("result changed under stall");

endmodule
